// ===== rtl/rrbm_pkg.sv =====
// Shared types and constants for the cartridge ROM/RAM bank mapper.
package rrbm_pkg;

    // Fixed bank geometry
    localparam int MAX_ROM_BANKS  = 128;
    localparam int RAM_BANK_BYTES = 8192;
    localparam int DEF_RAM_BANKS  = 4;

    localparam int ROM_BANK_W = 7;   // five low bits and two high bits
    localparam int ROM_OFF_W  = 14;  // 16KB window
    localparam int RAM_OFF_W  = 13;  // 8KB window
    localparam int RAM_IDX_W  = 15;  // widest cartridge RAM byte index
    localparam int ROM_ADDR_W = ROM_BANK_W + ROM_OFF_W;

    localparam logic [ROM_BANK_W-1:0] ROM_BANK_LIMIT_MASK = ROM_BANK_W'(MAX_ROM_BANKS - 1);

    // Access kinds
    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] CFG_MAPPER_PRESENT = 2'd0;
    localparam logic [1:0] CFG_ROM_BANK_COUNT = 2'd1;
    localparam logic [1:0] CFG_RAM_BANK_COUNT = 2'd2;

    // Control area selects, address bits 14:13 inside the ROM window
    localparam logic [1:0] CTL_RAM_ENABLE = 2'd0;
    localparam logic [1:0] CTL_LOW_BANK   = 2'd1;
    localparam logic [1:0] CTL_HIGH_BANK  = 2'd2;
    localparam logic [1:0] CTL_MODE       = 2'd3;

    // Address bits 15:13 of the cartridge RAM window
    localparam logic [2:0] RAM_WINDOW = 3'b101;

    localparam logic [3:0] RAM_ENABLE_KEY = 4'hA;
    localparam logic [7:0] OPEN_BUS       = 8'hFF;

    typedef struct packed {
        logic        cmd;
        logic [15:0] address;
        logic [7:0]  write_data;
    } req_t;

    typedef struct packed {
        logic [7:0]            read_data;
        logic                  rom_fetch;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic                  bad_access;
    } rsp_t;

    // Mapping outcome for one transaction, apart from the RAM byte
    typedef struct packed {
        logic                  rom_fetch;
        logic [ROM_ADDR_W-1:0] rom_address;
        logic                  bad_access;
        logic                  ram_read;
    } map_res_t;

    // One access to cartridge RAM
    typedef struct packed {
        logic                 rd_en;
        logic                 wr_en;
        logic [RAM_IDX_W-1:0] addr;
        logic [7:0]           wdata;
    } ram_req_t;

    // Configuration as seen by the mapping logic
    typedef struct packed {
        logic       mapper_present;
        logic [7:0] rom_bank_count;
        logic [2:0] ram_bank_count;
    } cfg_t;

endpackage

// ===== rtl/rom_ram_bank_mapper.sv =====
// Top level of the cartridge ROM/RAM bank mapper.
//
// Usage: the CPU side presents one bus transaction on req (cmd, address,
// write_data) with req_valid; it is taken at a clock edge where req_stall is
// low. Each transaction yields one result on rsp (read_data, rom_fetch,
// rom_address, bad_access) with rsp_valid; the receiver holds it with
// rsp_stall. Configuration is written through cfg_we, cfg_index and cfg_wdata
// while no transaction is in flight.
// An accepted transaction is held in the input register and its result is then
// registered in the result register, from which it is taken. Throughput is one
// transaction per cycle while rsp_stall stays low: the input register and the
// result register form a two-stage pipeline, and the bank mapping plus one
// cartridge RAM port access fit between them.
// Reset: bank registers take their power-on values, then a clearing sweep
// writes 0xFF to every cartridge RAM byte, one byte per cycle; req_stall stays
// high during the sweep. Configuration writes are taken throughout.
// Stall: while rsp_stall holds a result, one more transaction is buffered in
// the input register, after which req_stall rises.
module rom_ram_bank_mapper #(
    parameter int MAX_RAM_BANKS = rrbm_pkg::DEF_RAM_BANKS
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  rrbm_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output rrbm_pkg::rsp_t rsp,
    input  logic           cfg_we,
    input  logic [1:0]     cfg_index,
    input  logic [7:0]     cfg_wdata
);

    localparam int                          RAM_DEPTH = MAX_RAM_BANKS * rrbm_pkg::RAM_BANK_BYTES;
    localparam logic [rrbm_pkg::RAM_IDX_W-1:0] CLR_LAST = rrbm_pkg::RAM_IDX_W'(RAM_DEPTH - 1);

    rrbm_pkg::cfg_t     cfg_reg;
    rrbm_pkg::req_t     in_reg;
    logic               in_valid_reg;
    logic               out_valid_reg;
    logic               rom_fetch_reg;
    logic [rrbm_pkg::ROM_ADDR_W-1:0] rom_addr_reg;
    logic               bad_reg;
    logic               ram_rd_reg;
    logic               clr_active_reg;
    logic [rrbm_pkg::RAM_IDX_W-1:0] clr_addr_reg;

    logic               advance;
    logic               accept;
    rrbm_pkg::map_res_t map_res;
    rrbm_pkg::ram_req_t map_ram_req;
    rrbm_pkg::ram_req_t ram_req;
    logic [7:0]         ram_rdata;

    // Pipeline handshake
    assign advance   = in_valid_reg && (!out_valid_reg || !rsp_stall);
    assign req_stall = clr_active_reg || (in_valid_reg && !advance);
    assign accept    = req_valid && !req_stall;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.mapper_present <= 1'b1;
            cfg_reg.rom_bank_count <= 8'd2;
            cfg_reg.ram_bank_count <= 3'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                rrbm_pkg::CFG_MAPPER_PRESENT: cfg_reg.mapper_present <= cfg_wdata[0];
                rrbm_pkg::CFG_ROM_BANK_COUNT: cfg_reg.rom_bank_count <= cfg_wdata;
                rrbm_pkg::CFG_RAM_BANK_COUNT: cfg_reg.ram_bank_count <= cfg_wdata[2:0];
                default:                      cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Clear cartridge RAM after reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
        end
        else if (clr_active_reg)
        begin
            clr_addr_reg <= clr_addr_reg + rrbm_pkg::RAM_IDX_W'(1);
            if (clr_addr_reg == CLR_LAST)
            begin
                clr_active_reg <= 1'b0;
            end
        end
    end

    // Input register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    // Input payload, hold while waiting
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= req;
        end
    end

    // Result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!rsp_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rom_fetch_reg <= map_res.rom_fetch;
            rom_addr_reg  <= map_res.rom_address;
            bad_reg       <= map_res.bad_access;
            ram_rd_reg    <= map_res.ram_read;
        end
    end

    rrbm_map #(
        .MAX_RAM_BANKS(MAX_RAM_BANKS)
    ) u_map (
        .clk    (clk),
        .rst_n  (rst_n),
        .advance(advance),
        .req    (in_reg),
        .cfg    (cfg_reg),
        .res    (map_res),
        .ram_req(map_ram_req)
    );

    // Steer the RAM port to the clearing sweep after reset
    always_comb
    begin
        if (clr_active_reg)
        begin
            ram_req.rd_en = 1'b0;
            ram_req.wr_en = 1'b1;
            ram_req.addr  = clr_addr_reg;
            ram_req.wdata = rrbm_pkg::OPEN_BUS;
        end
        else
        begin
            ram_req = map_ram_req;
        end
    end

    rrbm_ram #(
        .MAX_RAM_BANKS(MAX_RAM_BANKS)
    ) u_ram (
        .clk  (clk),
        .req  (ram_req),
        .rdata(ram_rdata)
    );

    // Drive the result channel
    assign rsp_valid       = out_valid_reg;
    assign rsp.read_data   = ram_rd_reg ? ram_rdata : rrbm_pkg::OPEN_BUS;
    assign rsp.rom_fetch   = rom_fetch_reg;
    assign rsp.rom_address = rom_addr_reg;
    assign rsp.bad_access  = bad_reg;

    // No transaction enters during the clearing sweep
    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clr_active_reg |-> req_stall)
        else $error("transaction accepted during RAM clear");

    // A buffered transaction is not overwritten while the result is held
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && out_valid_reg && rsp_stall) |-> req_stall)
        else $error("input register overwritten under stall");

    // A result is a ROM fetch, a RAM read, an error or none, never two
    a_result_kind: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ($countones({rom_fetch_reg, ram_rd_reg, bad_reg}) <= 1))
        else $error("result carries more than one kind");

    // Every advance produces a valid result next cycle
    a_advance_result: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced transaction lost");

endmodule

// ===== rtl/rrbm_ram.sv =====
// Cartridge RAM: single-port byte array with registered read data.
module rrbm_ram #(
    parameter int MAX_RAM_BANKS = rrbm_pkg::DEF_RAM_BANKS
) (
    input  logic              clk,
    input  rrbm_pkg::ram_req_t req,
    output logic [7:0]        rdata
);

    localparam int DEPTH = MAX_RAM_BANKS * rrbm_pkg::RAM_BANK_BYTES;
    localparam int AW    = $clog2(DEPTH);

    logic [7:0]    mem [DEPTH];
    logic [7:0]    rdata_reg;
    logic [AW-1:0] addr;

    assign addr  = req.addr[AW-1:0];
    assign rdata = rdata_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[addr] <= req.wdata;
        end
    end

    // Read port, hold data when not reading
    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

endmodule

// ===== rtl/rrbm_map.sv =====
// Bank registers and address mapping for one bus transaction.
module rrbm_map #(
    parameter int MAX_RAM_BANKS = rrbm_pkg::DEF_RAM_BANKS
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    input  rrbm_pkg::req_t      req,
    input  rrbm_pkg::cfg_t      cfg,
    output rrbm_pkg::map_res_t  res,
    output rrbm_pkg::ram_req_t  ram_req
);

    localparam logic [2:0] RAM_BANK_LIMIT = 3'(MAX_RAM_BANKS);

    logic       ram_on_reg, ram_on_next;
    logic [4:0] low_bank_reg, low_bank_next;
    logic [1:0] high_bank_reg, high_bank_next;
    logic       adv_mode_reg, adv_mode_next;

    logic                                in_rom;
    logic                                in_ram;
    logic                                is_wr;
    logic [1:0]                          high_sel;
    logic [rrbm_pkg::ROM_BANK_W-1:0]     rom_mask;
    logic [rrbm_pkg::ROM_BANK_W-1:0]     rom_bank;
    logic [2:0]                          ram_mask;
    logic [1:0]                          ram_bank_sel;
    logic                                ram_live;

    assign in_rom   = !req.address[15];
    assign in_ram   = (req.address[15:13] == rrbm_pkg::RAM_WINDOW);
    assign is_wr    = (req.cmd == rrbm_pkg::CMD_WRITE);
    assign high_sel = adv_mode_reg ? high_bank_reg : 2'd0;

    // Select and mask the ROM bank
    assign rom_mask = 7'(cfg.rom_bank_count - 8'd1) & rrbm_pkg::ROM_BANK_LIMIT_MASK;
    assign rom_bank = (req.address[14] ? {high_bank_reg, low_bank_reg} : {high_sel, 5'd0})
                      & rom_mask;

    // Select and mask the RAM bank
    assign ram_mask = (cfg.ram_bank_count > RAM_BANK_LIMIT) ? (RAM_BANK_LIMIT - 3'd1)
                                                             : (cfg.ram_bank_count - 3'd1);
    assign ram_bank_sel = high_sel & ram_mask[1:0];
    assign ram_live = cfg.mapper_present && in_ram && ram_on_reg && (cfg.ram_bank_count != 3'd0);

    // Build the result flags and the RAM access
    always_comb
    begin
        res.rom_fetch   = 1'b0;
        res.rom_address = '0;
        res.bad_access  = 1'b0;
        res.ram_read    = 1'b0;

        if (!cfg.mapper_present)
        begin
            if (!is_wr && in_rom)
            begin
                res.rom_fetch   = 1'b1;
                res.rom_address = rrbm_pkg::ROM_ADDR_W'(req.address);
            end
            else
            begin
                res.bad_access = 1'b1;
            end
        end
        else if (in_rom)
        begin
            if (!is_wr)
            begin
                res.rom_fetch   = 1'b1;
                res.rom_address = {rom_bank, req.address[rrbm_pkg::ROM_OFF_W-1:0]};
            end
        end
        else if (in_ram)
        begin
            res.ram_read = ram_live && !is_wr;
        end
        else
        begin
            res.bad_access = 1'b1;
        end

        ram_req.rd_en = advance && ram_live && !is_wr;
        ram_req.wr_en = advance && ram_live && is_wr;
        ram_req.addr  = {ram_bank_sel, req.address[rrbm_pkg::RAM_OFF_W-1:0]};
        ram_req.wdata = req.write_data;
    end

    // Control writes into the ROM window
    always_comb
    begin
        ram_on_next    = ram_on_reg;
        low_bank_next  = low_bank_reg;
        high_bank_next = high_bank_reg;
        adv_mode_next  = adv_mode_reg;

        if (advance && cfg.mapper_present && in_rom && is_wr)
        begin
            case (req.address[14:13])
                rrbm_pkg::CTL_RAM_ENABLE:
                    ram_on_next = (req.write_data[3:0] == rrbm_pkg::RAM_ENABLE_KEY);
                rrbm_pkg::CTL_LOW_BANK:
                    low_bank_next = (req.write_data[4:0] == 5'd0) ? 5'd1 : req.write_data[4:0];
                rrbm_pkg::CTL_HIGH_BANK:
                    high_bank_next = req.write_data[1:0];
                rrbm_pkg::CTL_MODE:
                    adv_mode_next = req.write_data[0];
                default:
                    ram_on_next = ram_on_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ram_on_reg    <= 1'b0;
            low_bank_reg  <= 5'd1;
            high_bank_reg <= 2'd0;
            adv_mode_reg  <= 1'b0;
        end
        else
        begin
            ram_on_reg    <= ram_on_next;
            low_bank_reg  <= low_bank_next;
            high_bank_reg <= high_bank_next;
            adv_mode_reg  <= adv_mode_next;
        end
    end

    // Low bank never holds zero
    a_low_bank_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        low_bank_reg != 5'd0)
        else $error("low bank register holds zero");

    // RAM is never read and written in the same transaction
    a_ram_one_op: assert property (@(posedge clk) disable iff (!rst_n)
        !(ram_req.rd_en && ram_req.wr_en))
        else $error("RAM read and write in one transaction");

endmodule

// ===== tb/rom_ram_bank_mapper_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the cartridge ROM/RAM bank mapper.
module rom_ram_bank_mapper_tb;

    localparam int RAM_BYTES = rrbm_pkg::DEF_RAM_BANKS * rrbm_pkg::RAM_BANK_BYTES;

    logic           clk       = 1'b0;
    logic           rst_n     = 1'b0;
    logic           req_valid = 1'b0;
    logic           req_stall;
    rrbm_pkg::req_t req       = '0;
    logic           rsp_valid;
    logic           rsp_stall = 1'b0;
    rrbm_pkg::rsp_t rsp;
    logic           cfg_we    = 1'b0;
    logic [1:0]     cfg_index = '0;
    logic [7:0]     cfg_wdata = '0;

    rom_ram_bank_mapper u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // Predictor copy of configuration and mapper state
    logic       mdl_present;
    logic [7:0] mdl_rom_count;
    logic [2:0] mdl_ram_count;
    logic       mdl_ram_on;
    logic [4:0] mdl_low_bank;
    logic [1:0] mdl_high_bank;
    logic       mdl_adv_mode;
    logic [7:0] mdl_cart_ram [0:RAM_BYTES-1];

    rrbm_pkg::req_t pending_accesses[$];
    rrbm_pkg::rsp_t due_responses[$];
    int   outstanding    = 0;
    int   fault_count    = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    logic req_fired      = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Compute the response of one bus transaction and advance the mapper state
    function automatic rrbm_pkg::rsp_t map_access(input rrbm_pkg::req_t r);
        rrbm_pkg::rsp_t                  o;
        logic [rrbm_pkg::ROM_BANK_W-1:0] bank;
        logic [7:0]                      rom_mask;
        logic [2:0]                      ram_limit;
        logic [1:0]                      ram_bank_sel;
        logic [rrbm_pkg::RAM_IDX_W-1:0]  idx;
        logic                            in_rom;
        logic                            in_ram;
        o.read_data   = rrbm_pkg::OPEN_BUS;
        o.rom_fetch   = 1'b0;
        o.rom_address = '0;
        o.bad_access  = 1'b0;
        in_rom = !r.address[15];
        in_ram = (r.address[15:13] == rrbm_pkg::RAM_WINDOW);
        if (!mdl_present)
        begin
            if (r.cmd == rrbm_pkg::CMD_READ && in_rom)
            begin
                o.rom_fetch   = 1'b1;
                o.rom_address = rrbm_pkg::ROM_ADDR_W'(r.address);
            end
            else
                o.bad_access = 1'b1;
        end
        else if (in_rom)
        begin
            if (r.cmd == rrbm_pkg::CMD_WRITE)
            begin
                case (r.address[14:13])
                    rrbm_pkg::CTL_RAM_ENABLE:
                        mdl_ram_on = (r.write_data[3:0] == rrbm_pkg::RAM_ENABLE_KEY);
                    rrbm_pkg::CTL_LOW_BANK:
                        mdl_low_bank = (r.write_data[4:0] == 5'd0) ? 5'd1 : r.write_data[4:0];
                    rrbm_pkg::CTL_HIGH_BANK:
                        mdl_high_bank = r.write_data[1:0];
                    default:
                        mdl_adv_mode = r.write_data[0];
                endcase
            end
            else
            begin
                // Lower window sees only the upper bits, and only in advanced mode
                if (!r.address[14])
                    bank = mdl_adv_mode ? {mdl_high_bank, 5'd0} : '0;
                else
                    bank = {mdl_high_bank, mdl_low_bank};
                rom_mask      = (mdl_rom_count - 8'd1) & 8'(rrbm_pkg::MAX_ROM_BANKS - 1);
                bank          = bank & rom_mask[rrbm_pkg::ROM_BANK_W-1:0];
                o.rom_fetch   = 1'b1;
                o.rom_address = {bank, r.address[rrbm_pkg::ROM_OFF_W-1:0]};
            end
        end
        else if (in_ram)
        begin
            // Disabled or absent RAM drops writes and reads open bus
            if (mdl_ram_on && mdl_ram_count != 3'd0)
            begin
                ram_limit    = (mdl_ram_count > 3'(rrbm_pkg::DEF_RAM_BANKS))
                               ? 3'(rrbm_pkg::DEF_RAM_BANKS) : mdl_ram_count;
                ram_bank_sel = (mdl_adv_mode ? mdl_high_bank : 2'd0) & 2'(ram_limit - 3'd1);
                idx          = {ram_bank_sel, r.address[rrbm_pkg::RAM_OFF_W-1:0]};
                if (r.cmd == rrbm_pkg::CMD_WRITE)
                    mdl_cart_ram[idx] = r.write_data;
                else
                    o.read_data = mdl_cart_ram[idx];
            end
        end
        else
            o.bad_access = 1'b1;
        return o;
    endfunction

    task automatic flag_fault(input string what, input logic [31:0] got,
                              input logic [31:0] want);
        fault_count++;
        $display("%0t ERROR %s: got 0x%0h, want 0x%0h", $time, what, got, want);
    endtask

    // Sample both handshakes; check responses before queueing new predictions
    always @(posedge clk)
    begin
        rrbm_pkg::rsp_t want;
        req_fired = rst_n && req_valid && !req_stall;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (due_responses.size() == 0)
                flag_fault("response with no transaction pending", 32'(rsp), 32'd0);
            else
            begin
                want = due_responses.pop_front();
                outstanding--;
                if (rsp.read_data !== want.read_data)
                    flag_fault("read_data", 32'(rsp.read_data), 32'(want.read_data));
                if (rsp.rom_fetch !== want.rom_fetch)
                    flag_fault("rom_fetch", 32'(rsp.rom_fetch), 32'(want.rom_fetch));
                if (rsp.rom_address !== want.rom_address)
                    flag_fault("rom_address", 32'(rsp.rom_address), 32'(want.rom_address));
                if (rsp.bad_access !== want.bad_access)
                    flag_fault("bad_access", 32'(rsp.bad_access), 32'(want.bad_access));
            end
        end
        if (req_fired)
            due_responses.push_back(map_access(req));
    end

    // Present the next transaction once the current one is taken
    always @(negedge clk)
    begin
        if (!req_valid || req_fired)
        begin
            if (pending_accesses.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                req       <= pending_accesses.pop_front();
                req_valid <= 1'b1;
            end
            else
                req_valid <= 1'b0;
        end
    end

    // Stall the response side at random
    always @(negedge clk)
    begin
        rsp_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    function automatic void queue_access(input rrbm_pkg::req_t r);
        pending_accesses.push_back(r);
        outstanding++;
    endfunction

    // Mostly well-formed traffic: bank setup, ROM fetches, RAM traffic mostly on small offset pools at both window ends
    function automatic rrbm_pkg::req_t random_access();
        rrbm_pkg::req_t r;
        int             pick;
        pick         = $urandom_range(0, 99);
        r.cmd        = 1'($urandom_range(0, 1));
        r.write_data = 8'($urandom_range(0, 255));
        r.address    = '0;
        if (pick < 14)
        begin
            r.cmd     = rrbm_pkg::CMD_WRITE;
            r.address = 16'($urandom_range(0, 16'h7FFF));
            if (r.address[14:13] == rrbm_pkg::CTL_RAM_ENABLE && $urandom_range(0, 3) != 0)
                r.write_data[3:0] = rrbm_pkg::RAM_ENABLE_KEY;
        end
        else if (pick < 40)
        begin
            r.cmd     = rrbm_pkg::CMD_READ;
            r.address = 16'($urandom_range(0, 16'h7FFF));
        end
        else if (pick < 88)
        begin
            r.address[15:13] = rrbm_pkg::RAM_WINDOW;
            case ($urandom_range(0, 3))
                0:       r.address[12:0] = 13'($urandom_range(0, 8191));
                1:       r.address[12:0] = 13'h1FFF - 13'($urandom_range(0, 7));
                default: r.address[12:0] = 13'($urandom_range(0, 15));
            endcase
        end
        else
            r.address = 16'($urandom_range(0, 16'hFFFF));
        return r;
    endfunction

    // Hold until every transaction has its response, then let the pipeline settle
    task automatic wait_idle();
        do
            @(negedge clk);
        while (outstanding != 0);
        repeat (4) @(negedge clk);
    endtask

    task automatic cfg_write(input logic [1:0] idx, input logic [7:0] val);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            rrbm_pkg::CFG_MAPPER_PRESENT: mdl_present = val[0];
            rrbm_pkg::CFG_ROM_BANK_COUNT: mdl_rom_count = val;
            default:                      mdl_ram_count = val[2:0];
        endcase
    endtask

    // Drain, reprogram all configuration registers, and set the idle mix
    task automatic start_phase(input logic mp, input logic [7:0] rom_cnt,
                               input logic [7:0] ram_cnt, input int s_idle, input int r_idle);
        wait_idle();
        cfg_write(rrbm_pkg::CFG_MAPPER_PRESENT, {7'd0, mp});
        cfg_write(rrbm_pkg::CFG_ROM_BANK_COUNT, rom_cnt);
        cfg_write(rrbm_pkg::CFG_RAM_BANK_COUNT, ram_cnt);
        @(negedge clk);
        cfg_we <= 1'b0;
        send_idle_pct  = s_idle;
        recv_stall_pct = r_idle;
    endtask

    initial
    begin
        // Power-on state of the predictor
        mdl_present   = 1'b1;
        mdl_rom_count = 8'd2;
        mdl_ram_count = 3'd0;
        mdl_ram_on    = 1'b0;
        mdl_low_bank  = 5'd1;
        mdl_high_bank = 2'd0;
        mdl_adv_mode  = 1'b0;
        for (int i = 0; i < RAM_BYTES; i++)
            mdl_cart_ram[i] = rrbm_pkg::OPEN_BUS;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed: window edges, every control area, RAM enable, bank zero, outside areas
        start_phase(1'b1, 8'd128, 8'd4, 0, 0);
        queue_access('{rrbm_pkg::CMD_READ,  16'h0000, 8'hFF});
        queue_access('{rrbm_pkg::CMD_READ,  16'h3FFF, 8'h00});
        queue_access('{rrbm_pkg::CMD_READ,  16'h4000, 8'h00});
        queue_access('{rrbm_pkg::CMD_READ,  16'h7FFF, 8'h00});
        queue_access('{rrbm_pkg::CMD_READ,  16'hA000, 8'h00});
        queue_access('{rrbm_pkg::CMD_WRITE, 16'h0000, 8'hFA});
        queue_access('{rrbm_pkg::CMD_WRITE, 16'hA000, 8'h5A});
        queue_access('{rrbm_pkg::CMD_READ,  16'hA000, 8'h00});
        queue_access('{rrbm_pkg::CMD_READ,  16'hBFFF, 8'h00});
        queue_access('{rrbm_pkg::CMD_WRITE, 16'h2000, 8'hE0});
        queue_access('{rrbm_pkg::CMD_READ,  16'h4000, 8'h00});
        queue_access('{rrbm_pkg::CMD_WRITE, 16'h3FFF, 8'hFF});
        queue_access('{rrbm_pkg::CMD_WRITE, 16'h4000, 8'hFF});
        queue_access('{rrbm_pkg::CMD_WRITE, 16'h6000, 8'h01});
        queue_access('{rrbm_pkg::CMD_READ,  16'h0000, 8'h00});
        queue_access('{rrbm_pkg::CMD_READ,  16'h7FFF, 8'h00});
        queue_access('{rrbm_pkg::CMD_WRITE, 16'hBFFF, 8'h00});
        queue_access('{rrbm_pkg::CMD_READ,  16'hBFFF, 8'hFF});
        queue_access('{rrbm_pkg::CMD_WRITE, 16'h7FFF, 8'hFE});
        queue_access('{rrbm_pkg::CMD_READ,  16'hBFFF, 8'h00});
        queue_access('{rrbm_pkg::CMD_WRITE, 16'h1FFF, 8'h1B});
        queue_access('{rrbm_pkg::CMD_READ,  16'hA000, 8'h00});
        queue_access('{rrbm_pkg::CMD_WRITE, 16'hA000, 8'h33});
        queue_access('{rrbm_pkg::CMD_READ,  16'h8000, 8'h00});
        queue_access('{rrbm_pkg::CMD_WRITE, 16'h9FFF, 8'h12});
        queue_access('{rrbm_pkg::CMD_READ,  16'hC000, 8'h00});
        queue_access('{rrbm_pkg::CMD_WRITE, 16'hFFFF, 8'h34});

        // Random phases across configurations and idle mixes
        start_phase(1'b1, 8'd128, 8'd4, 0, 0);
        repeat (120) queue_access(random_access());
        start_phase(1'b1, 8'd2, 8'd0, 86, 0);
        repeat (100) queue_access(random_access());
        start_phase(1'b1, 8'd32, 8'd1, 0, 86);
        repeat (100) queue_access(random_access());
        start_phase(1'b1, 8'd64, 8'd4, 38, 38);
        repeat (120) queue_access(random_access());

        // Plain cartridge: ROM reads pass through, everything else is flagged
        start_phase(1'b0, 8'd2, 8'd0, 38, 0);
        queue_access('{rrbm_pkg::CMD_READ,  16'h7FFF, 8'h00});
        queue_access('{rrbm_pkg::CMD_WRITE, 16'h2000, 8'h05});
        queue_access('{rrbm_pkg::CMD_READ,  16'hA000, 8'h00});
        repeat (60) queue_access(random_access());

        // Odd counts: zero and oversized ROM bank counts, out-of-range and odd RAM bank counts
        start_phase(1'b1, 8'd0, 8'd7, 0, 0);
        repeat (60) queue_access(random_access());
        start_phase(1'b1, 8'd255, 8'd2, 86, 86);
        repeat (40) queue_access(random_access());
        start_phase(1'b1, 8'd16, 8'd3, 0, 38);
        repeat (30) queue_access(random_access());

        wait_idle();
        repeat (10) @(posedge clk);
        if (fault_count == 0)
            $display("rom_ram_bank_mapper: match");
        else
            $display("rom_ram_bank_mapper: mismatch");
        $finish;
    end

    // Watchdog
    initial
    begin
        #5_000_000;
        $display("rom_ram_bank_mapper: mismatch");
        $finish;
    end

endmodule
